// ----- hdl/trist_pkg.sv -----
// Shared types and constants for the touch report I2C slave translator.
// Holds op codes, command and event codes, byte array type and control structs.
// No dependencies.
package trist_pkg;

    localparam int unsigned BUF_BYTES_DEF = 16;
    localparam int unsigned REC_BYTES     = 16;
    localparam int unsigned DIST_W        = 16;
    localparam int unsigned ROOT_W        = 35;
    localparam int unsigned ACC_W         = 34;

    localparam logic [2:0] OP_REPORT = 3'd0;
    localparam logic [2:0] OP_ADDR   = 3'd1;
    localparam logic [2:0] OP_RX     = 3'd2;
    localparam logic [2:0] OP_TX     = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;

    localparam logic [7:0] CMD_STATUS = 8'h0F;
    localparam logic [7:0] CMD_POINT  = 8'h10;
    localparam logic [7:0] CMD_AE     = 8'hAE;
    localparam logic [7:0] CMD_E1     = 8'hE1;
    localparam logic [7:0] CMD_F6     = 8'hF6;
    localparam logic [7:0] CMD_02     = 8'h02;
    localparam logic [7:0] CMD_0B     = 8'h0B;
    localparam logic [7:0] CMD_E2     = 8'hE2;
    localparam logic [7:0] CMD_E3     = 8'hE3;
    localparam logic [7:0] CMD_F3     = 8'hF3;
    localparam logic [7:0] CMD_F4     = 8'hF4;
    localparam logic [7:0] CMD_F5     = 8'hF5;
    localparam logic [7:0] CMD_F0     = 8'hF0;
    localparam logic [7:0] CMD_F1     = 8'hF1;
    localparam logic [7:0] CMD_F2     = 8'hF2;

    localparam logic [7:0] EV_DOWN1 = 8'hA1;
    localparam logic [7:0] EV_DOWN2 = 8'hA2;
    localparam logic [7:0] EV_PALM1 = 8'hB1;
    localparam logic [7:0] EV_PALM2 = 8'hB2;
    localparam logic [7:0] EV_UP1   = 8'h21;
    localparam logic [7:0] EV_UP2   = 8'h22;

    localparam logic [7:0] ST_IDLE    = 8'h08;
    localparam logic [7:0] ST_EVENT   = 8'h10;
    localparam logic [7:0] ST_UP      = 8'h08;
    localparam logic [7:0] ST_UP_PALM = 8'h88;

    typedef logic [15:0][7:0] t_bytes16;

    typedef struct packed {
        logic exec;
        logic mul_x;
        logic mul_y;
        logic root_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_root;
        logic out_busy;
        logic root_done;
    } t_stat;

endpackage

// ----- hdl/trist_isqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
// Depends on trist_pkg for widths.
module trist_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [trist_pkg::ROOT_W-1:0] i_radicand,
    output logic                         o_done,
    output logic [trist_pkg::ROOT_W-1:0] o_root
);

    localparam int unsigned W = trist_pkg::ROOT_W;

    logic [W-1:0] r_n;
    logic [W-1:0] r_res;
    logic [W-1:0] r_bit;
    logic         r_busy;
    logic         r_done;
    logic [W:0]   v_sum;
    logic         v_ge;

    always_comb begin
        v_sum = {1'b0, r_res} + {1'b0, r_bit};
        v_ge  = {1'b0, r_n} >= v_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_radicand;
            r_res <= '0;
            r_bit <= W'(1) << (W - 1);
        end else if (r_busy) begin
            if (v_ge) begin
                r_n   <= r_n - v_sum[W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res;

endmodule

// ----- hdl/trist_dp.sv -----
// Datapath: report, record and command stores, indices, pinch tracking, output word.
// Depends on trist_pkg and trist_isqrt.
module trist_dp #(
    parameter int unsigned BUF_BYTES = trist_pkg::BUF_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trist_pkg::t_cmd  i_cmd,
    output trist_pkg::t_stat o_stat,
    input  logic [2:0]       i_op,
    input  logic [63:0]      i_report_low,
    input  logic [63:0]      i_report_high,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_tx_valid,
    output logic             o_int_level
);

    localparam int unsigned IDX_W = $clog2(BUF_BYTES + 1);
    localparam int unsigned ACC_W = trist_pkg::ACC_W;
    localparam int unsigned DW    = trist_pkg::DIST_W;
    localparam int unsigned RW    = trist_pkg::ROOT_W;

    function automatic trist_pkg::t_bytes16 put_finger(trist_pkg::t_bytes16 r,
                                                       trist_pkg::t_bytes16 rep,
                                                       logic hi, logic f);
        trist_pkg::t_bytes16 v;
        logic [3:0]          o;
        v = r;
        o = f ? 4'd6 : 4'd0;
        v[{hi, 3'd1}] = {rep[4'd7 + o][3:0], rep[4'd5 + o][3:0]};
        v[{hi, 3'd2}] = rep[4'd4 + o];
        v[{hi, 3'd3}] = rep[4'd6 + o];
        v[{hi, 3'd5}] = rep[4'd8 + o];
        return v;
    endfunction

    trist_pkg::t_bytes16 r_rep, n_rep;
    trist_pkg::t_bytes16 r_resp, n_resp;
    logic [7:0]       r_cmd0, n_cmd0;
    logic [IDX_W-1:0] r_rx_idx, n_rx_idx;
    logic [IDX_W-1:0] r_tx_idx, n_tx_idx;
    logic [DW-1:0]    r_last, n_last;
    logic             r_pin, n_pin, r_pout, n_pout, r_two, n_two;
    logic             r_bup, n_bup, r_fup, n_fup, r_sup, n_sup;
    logic             r_host, n_host;
    logic [15:0]      r_dx, n_dx, r_dy, n_dy;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_tx_byte, n_tx_byte;
    logic             r_txv, n_txv;
    logic             r_int, n_int;

    trist_pkg::t_bytes16 in_rep;
    trist_pkg::t_bytes16 dec_resp;
    logic             dec_two, dec_bup, dec_fup, dec_sup;
    logic [7:0]       v_cmd0;
    logic [7:0]       v_tx;
    logic             v_txv;
    logic [15:0]      x0, x1, y0, y1;
    logic [DW-1:0]    v_d;
    logic             root_done;
    logic [RW-1:0]    root;
    logic [7:0]       b0, b9, b15, g;

    assign in_rep = {i_report_high, i_report_low};
    assign x0 = {in_rep[5], in_rep[4]};
    assign y0 = {in_rep[7], in_rep[6]};
    assign x1 = {in_rep[11], in_rep[10]};
    assign y1 = {in_rep[13], in_rep[12]};
    assign b0  = r_rep[0];
    assign b9  = r_rep[9];
    assign b15 = r_rep[15];
    assign g   = r_rep[2];
    assign v_cmd0 = (r_rx_idx == '0) ? i_rx_byte : r_cmd0;

    trist_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.root_start),
        .i_radicand ({1'b0, r_acc}),
        .o_done     (root_done),
        .o_root     (root)
    );

    always_comb begin
        o_stat.need_root = (i_op == trist_pkg::OP_REPORT) && in_rep[15][0]
                           && (in_rep[15][2] || in_rep[9][2]);
        o_stat.out_busy  = r_out_valid;
        o_stat.root_done = root_done;
    end

    always_comb begin
        dec_resp = r_resp;
        dec_two  = r_two;
        dec_bup  = r_bup;
        dec_fup  = r_fup;
        dec_sup  = r_sup;
        case (v_cmd0)
            trist_pkg::CMD_STATUS: begin
                dec_resp[0] = trist_pkg::ST_IDLE;
                if (b9[2] && b15[2]) dec_resp[0] = trist_pkg::ST_EVENT;
                if (r_two && !b9[0] && !b15[0]) begin
                    dec_resp[0] = trist_pkg::ST_EVENT;
                    dec_bup = 1'b1;
                end
                if (r_two && b9[2] && !b15[0]) begin
                    dec_resp[0] = trist_pkg::ST_EVENT;
                    dec_sup = 1'b1;
                end
                if (r_two && !b9[0] && b15[2]) begin
                    dec_resp[0] = trist_pkg::ST_EVENT;
                    dec_fup = 1'b1;
                end
            end
            trist_pkg::CMD_AE: dec_resp[0] = 8'h26;
            trist_pkg::CMD_E1: begin
                dec_resp[0] = 8'h04; dec_resp[1] = 8'h82;
                dec_resp[2] = 8'h07; dec_resp[3] = 8'h00;
            end
            trist_pkg::CMD_F6: begin
                dec_resp[0] = 8'h55; dec_resp[1] = 8'h56; dec_resp[2] = 8'h32;
                dec_resp[3] = 8'h00; dec_resp[4] = 8'h00; dec_resp[5] = 8'h00;
                dec_resp[6] = 8'h00; dec_resp[7] = 8'h00;
                dec_resp[8] = 8'h11; dec_resp[9] = 8'h08;
            end
            trist_pkg::CMD_02: begin
                dec_resp[0] = 8'h54; dec_resp[1] = 8'h00;
                dec_resp[2] = 8'h00; dec_resp[3] = 8'h00;
            end
            trist_pkg::CMD_0B: begin
                dec_resp[0] = 8'h13; dec_resp[1] = 8'h0C; dec_resp[2] = 8'h00;
            end
            trist_pkg::CMD_E2: dec_resp[0] = 8'h82;
            trist_pkg::CMD_E3, trist_pkg::CMD_F3, trist_pkg::CMD_F4,
            trist_pkg::CMD_F5: dec_resp[0] = 8'h07;
            trist_pkg::CMD_F0: dec_resp[0] = 8'h04;
            trist_pkg::CMD_F1, trist_pkg::CMD_F2: dec_resp[0] = 8'h45;
            trist_pkg::CMD_POINT: begin
                dec_resp = '0;
                if (b9[0]) begin
                    dec_resp[0] = trist_pkg::EV_DOWN1;
                    dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b0);
                    if (b9[7]) dec_resp[0] = trist_pkg::EV_PALM1;
                end
                if (!b9[0] && b15[0]) begin
                    dec_resp[0] = trist_pkg::EV_DOWN2;
                    dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b1);
                    if (b15[7]) dec_resp[0] = trist_pkg::EV_PALM2;
                end
                if (b9[0] && b15[0]) begin
                    dec_two = 1'b1;
                    dec_resp[0] = trist_pkg::EV_DOWN1;
                    dec_resp[8] = trist_pkg::EV_DOWN2;
                    dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b0);
                    dec_resp = put_finger(dec_resp, r_rep, 1'b1, 1'b1);
                    if (!b9[2] && b15[2]) begin
                        dec_resp[0] = trist_pkg::EV_DOWN2;
                        dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b1);
                        if (b15[7]) dec_resp[0] = trist_pkg::EV_PALM2;
                        if (b9[7]) dec_resp[0] = trist_pkg::EV_PALM1;
                        if (b15[7]) dec_resp[8] = trist_pkg::EV_PALM2;
                    end
                end else begin
                    dec_two = 1'b0;
                end
                if (b0[0] && b0[3]) begin
                    if (b9 == trist_pkg::ST_UP || b9 == trist_pkg::ST_UP_PALM) begin
                        dec_resp[0] = trist_pkg::EV_UP1;
                        dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b0);
                    end
                    if (b15 == trist_pkg::ST_UP || b15 == trist_pkg::ST_UP_PALM) begin
                        dec_resp[0] = trist_pkg::EV_UP2;
                        dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b1);
                    end
                    if (r_bup) begin
                        dec_bup = 1'b0;
                        dec_resp[0] = trist_pkg::EV_UP1;
                        dec_resp[8] = trist_pkg::EV_UP2;
                        dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b0);
                        dec_resp = put_finger(dec_resp, r_rep, 1'b1, 1'b1);
                    end
                    if (r_fup) begin
                        dec_fup = 1'b0;
                        dec_resp[0] = trist_pkg::EV_UP1;
                        dec_resp[8] = trist_pkg::EV_DOWN2;
                        dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b0);
                        dec_resp = put_finger(dec_resp, r_rep, 1'b1, 1'b1);
                    end
                    if (r_sup) begin
                        dec_sup = 1'b0;
                        dec_resp[0] = trist_pkg::EV_DOWN1;
                        dec_resp[8] = trist_pkg::EV_UP2;
                        dec_resp = put_finger(dec_resp, r_rep, 1'b0, 1'b0);
                        dec_resp = put_finger(dec_resp, r_rep, 1'b1, 1'b1);
                    end
                end
                if (g == 8'h05) dec_resp[7] = 8'h07;
                if (g == 8'h01) dec_resp[7] = 8'h03;
                if (g == 8'h03) dec_resp[7] = 8'h05;
                if (g == 8'h07) dec_resp[7] = 8'h01;
                if (g[2:0] != 3'd0) dec_resp[6] = 8'h01;
                if (r_pout) begin
                    dec_resp[6]  = 8'h03;
                    dec_resp[14] = 8'h03;
                end
                if (r_pin) begin
                    dec_resp[6]  = 8'h04;
                    dec_resp[14] = 8'h04;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_rep = r_rep; n_resp = r_resp; n_cmd0 = r_cmd0;
        n_rx_idx = r_rx_idx; n_tx_idx = r_tx_idx; n_last = r_last;
        n_pin = r_pin; n_pout = r_pout; n_two = r_two;
        n_bup = r_bup; n_fup = r_fup; n_sup = r_sup; n_host = r_host;
        n_dx = r_dx; n_dy = r_dy; n_acc = r_acc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_tx_byte = r_tx_byte; n_txv = r_txv; n_int = r_int;
        v_tx = 8'h00;
        v_txv = 1'b0;
        v_d = (root > RW'(16'hFFFF)) ? 16'hFFFF : root[DW-1:0];
        if (i_cmd.exec) begin
            case (i_op)
                trist_pkg::OP_REPORT: begin
                    n_rep  = in_rep;
                    n_host = 1'b0;
                    n_dx   = (x0 > x1) ? x0 - x1 : x1 - x0;
                    n_dy   = (y0 > y1) ? y0 - y1 : y1 - y0;
                    if (!in_rep[15][0]) begin
                        n_last = '0;
                        n_pin  = 1'b0;
                        n_pout = 1'b0;
                    end
                end
                trist_pkg::OP_ADDR: begin
                    n_rx_idx = '0;
                    n_tx_idx = '0;
                end
                trist_pkg::OP_RX: begin
                    if (r_rx_idx < IDX_W'(BUF_BYTES)) begin
                        n_cmd0   = v_cmd0;
                        n_rx_idx = r_rx_idx + IDX_W'(1);
                    end
                    n_resp = dec_resp;
                    n_two  = dec_two;
                    n_bup  = dec_bup;
                    n_fup  = dec_fup;
                    n_sup  = dec_sup;
                end
                trist_pkg::OP_TX: begin
                    v_txv = 1'b1;
                    if (r_tx_idx < IDX_W'(BUF_BYTES)) begin
                        if (r_tx_idx < IDX_W'(trist_pkg::REC_BYTES)) begin
                            v_tx = r_resp[r_tx_idx[3:0]];
                        end
                        n_tx_idx = r_tx_idx + IDX_W'(1);
                    end
                end
                trist_pkg::OP_STOP: begin
                    if (r_cmd0 == trist_pkg::CMD_POINT) n_host = 1'b1;
                end
                default: ;
            endcase
            if (!o_stat.need_root) begin
                n_out_valid = 1'b1;
                n_tx_byte   = v_tx;
                n_txv       = v_txv;
                n_int       = n_host;
            end
        end
        if (i_cmd.mul_x) n_acc = ACC_W'(32'(r_dx) * 32'(r_dx));
        if (i_cmd.mul_y) n_acc = r_acc + ACC_W'(32'(r_dy) * 32'(r_dy));
        if (i_cmd.finish) begin
            if (r_last != '0) begin
                if (v_d < r_last) n_pin = 1'b1;
                if (v_d > r_last) n_pout = 1'b1;
            end
            n_last      = v_d;
            n_out_valid = 1'b1;
            n_tx_byte   = 8'h00;
            n_txv       = 1'b0;
            n_int       = r_host;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= '0; r_resp <= '0; r_cmd0 <= '0;
            r_rx_idx <= '0; r_tx_idx <= '0; r_last <= '0;
            r_pin <= 1'b0; r_pout <= 1'b0; r_two <= 1'b0;
            r_bup <= 1'b0; r_fup <= 1'b0; r_sup <= 1'b0;
            r_host <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_rep <= n_rep; r_resp <= n_resp; r_cmd0 <= n_cmd0;
            r_rx_idx <= n_rx_idx; r_tx_idx <= n_tx_idx; r_last <= n_last;
            r_pin <= n_pin; r_pout <= n_pout; r_two <= n_two;
            r_bup <= n_bup; r_fup <= n_fup; r_sup <= n_sup;
            r_host <= n_host;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_acc <= n_acc;
        r_tx_byte <= n_tx_byte;
        r_txv <= n_txv;
        r_int <= n_int;
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_tx_valid  = r_txv;
    assign o_int_level = r_int;

    a_rx_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_idx <= IDX_W'(BUF_BYTES)) else $error("rx index past buffer");
    a_tx_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_idx <= IDX_W'(BUF_BYTES)) else $error("tx index past buffer");
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_txv |-> r_tx_byte == 8'h00) else $error("stray tx byte");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_out_valid) else $error("output word overwritten");

endmodule

// ----- hdl/trist_ctrl.sv -----
// Controller: sequences acceptance, the squaring steps and the root unit.
// Depends on trist_pkg.
module trist_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_out_ready,
    input  trist_pkg::t_stat i_stat,
    output logic             o_ready,
    output trist_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MULX  = 3'd1;
    localparam logic [2:0] S_MULY  = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign o_ready = (r_state == S_IDLE) && (!i_stat.out_busy || i_out_ready);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.exec = accept;
                if (accept && i_stat.need_root) n_state = S_MULX;
            end
            S_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state = S_MULY;
            end
            S_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state = S_START;
            end
            S_START: begin
                o_cmd.root_start = 1'b1;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (i_stat.root_done) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/touch_report_i2c_slave_translator_core.sv -----
// Top level of the touch report I2C slave translator.
// Depends on trist_pkg, trist_ctrl, trist_dp and trist_isqrt.
//
// Input channel (i_valid/o_ready) carries one word per I2C or report event:
// i_op selects touch report, address match, received byte, transmit request
// or stop. Output channel (o_valid/i_ready) returns exactly one word per
// input word: o_tx_byte/o_tx_valid answer transmit requests, o_int_level is
// the host interrupt line after the event (0 = pending).
// Every event except a touch report with finger 2 down and a finger moving
// has its output word registered on acceptance; that one runs two squaring
// steps, a root start, an 18-step iterative square root and a finish step,
// in that order, from acceptance to the output word.
// Throughput: one word per cycle for short events while the receiver takes
// the words; a distance report holds o_ready low until its root unit is done.
// The output word sits in a register; a new input is taken in the cycle the
// pending word leaves, and o_ready drops while the receiver stalls with a word
// pending.
// Reset clears all stores, indices and flags and sets the interrupt flag high.
module touch_report_i2c_slave_translator_core #(
    parameter int unsigned BUF_BYTES = trist_pkg::BUF_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [63:0] i_report_low,
    input  logic [63:0] i_report_high,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic        o_int_level
);

    trist_pkg::t_cmd  cmd;
    trist_pkg::t_stat stat;

    trist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    trist_dp #(
        .BUF_BYTES (BUF_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_op),
        .i_report_low  (i_report_low),
        .i_report_high (i_report_high),
        .i_rx_byte     (i_rx_byte),
        .i_out_ready   (i_ready),
        .o_out_valid   (o_valid),
        .o_tx_byte     (o_tx_byte),
        .o_tx_valid    (o_tx_valid),
        .o_int_level   (o_int_level)
    );

endmodule

// ----- tb/tb_touch_report_i2c_slave_translator_core.sv -----
// Testbench for the touch report I2C slave translator core.
// Drives report, address, receive, transmit and stop words and checks every reply
// against an in-bench model of the slave. Depends on trist_pkg and the core RTL.
module tb_touch_report_i2c_slave_translator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NBUF = 16;
    localparam logic [2:0] OP_NONE = 3'd5;
    localparam logic [2:0] OP_LAST = 3'd7;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       int_level;
    } t_reply;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [7:0]  rx;
        logic        has_exp;
        t_reply      exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_op = '0;
    logic [63:0] i_report_low = '0;
    logic [63:0] i_report_high = '0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_tx_byte;
    logic        o_tx_valid;
    logic        o_int_level;

    touch_report_i2c_slave_translator_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // slave model state
    logic [7:0]  rpt [16];
    logic [7:0]  resp [NBUF];
    logic [7:0]  cmdb [NBUF];
    int unsigned rx_idx, tx_idx;
    logic [15:0] last_dist;
    logic        pin, pout, two_dn, both_up, first_up, second_up, hint;

    t_reply reply_q [$];
    int     errors = 0;
    int     n_checked = 0;
    int     n_tx = 0;
    int     n_point = 0;
    bit     quiet = 1'b0;
    bit     all_sent = 1'b0;

    function automatic logic [33:0] root34(logic [34:0] n);
        logic [35:0] r, b;
        logic [35:0] v;
        v = {1'b0, n};
        r = '0;
        b = 36'd1 << 34;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[33:0];
    endfunction

    function automatic void put_finger(int base, int f);
        int o;
        o = f ? 6 : 0;
        resp[base+1] = {rpt[7+o][3:0], rpt[5+o][3:0]};
        resp[base+2] = rpt[4+o];
        resp[base+3] = rpt[6+o];
        resp[base+5] = rpt[8+o];
    endfunction

    function automatic void one_finger1();
        put_finger(0, 0);
        if (rpt[9][7] && rpt[9][0]) resp[0] = trist_pkg::EV_PALM1;
    endfunction

    function automatic void one_finger2();
        put_finger(0, 1);
        if (rpt[15][7] && rpt[15][0]) resp[0] = trist_pkg::EV_PALM2;
    endfunction

    function automatic void both_fingers();
        put_finger(0, 0);
        put_finger(8, 1);
    endfunction

    function automatic void store_report(logic [63:0] lo, logic [63:0] hi);
        logic [15:0] x0, y0, x1, y1, dx, dy;
        logic [33:0] d;
        logic [15:0] ds;
        for (int i = 0; i < 8; i++) begin
            rpt[i]   = lo[8*i +: 8];
            rpt[8+i] = hi[8*i +: 8];
        end
        if (rpt[15][0]) begin
            if (rpt[15][2] || rpt[9][2]) begin
                x0 = {rpt[5], rpt[4]};
                y0 = {rpt[7], rpt[6]};
                x1 = {rpt[11], rpt[10]};
                y1 = {rpt[13], rpt[12]};
                dx = x0 > x1 ? x0 - x1 : x1 - x0;
                dy = y0 > y1 ? y0 - y1 : y1 - y0;
                d = root34(35'(dx) * 35'(dx) + 35'(dy) * 35'(dy));
                ds = d > 34'hFFFF ? 16'hFFFF : d[15:0];
                if (last_dist > 0) begin
                    if (ds < last_dist) pin = 1'b1;
                    if (ds > last_dist) pout = 1'b1;
                end
                last_dist = ds;
            end
        end else begin
            last_dist = '0;
            pin = 1'b0;
            pout = 1'b0;
        end
        hint = 1'b0;
    endfunction

    function automatic void build_points();
        logic [7:0] b9, b15, b0, g;
        logic f1, f2;
        b9 = rpt[9];
        b15 = rpt[15];
        b0 = rpt[0];
        g = rpt[2];
        f1 = b9[0];
        f2 = b15[0];
        n_point++;
        for (int i = 0; i < NBUF; i++) resp[i] = 8'h00;
        if (f1) begin
            resp[0] = trist_pkg::EV_DOWN1;
            one_finger1();
        end
        if (!f1 && f2) begin
            resp[0] = trist_pkg::EV_DOWN2;
            one_finger2();
        end
        if (f1 && f2) begin
            two_dn = 1'b1;
            resp[0] = trist_pkg::EV_DOWN1;
            resp[8] = trist_pkg::EV_DOWN2;
            both_fingers();
            if (!b9[2] && b15[2]) begin
                resp[0] = trist_pkg::EV_DOWN2;
                one_finger2();
                if (b9[7]) resp[0] = trist_pkg::EV_PALM1;
                if (b15[7]) resp[8] = trist_pkg::EV_PALM2;
            end
        end else begin
            two_dn = 1'b0;
        end
        if (b0[0] && b0[3]) begin
            if (b9 == trist_pkg::ST_UP || b9 == trist_pkg::ST_UP_PALM) begin
                resp[0] = trist_pkg::EV_UP1;
                one_finger1();
            end
            if (b15 == trist_pkg::ST_UP || b15 == trist_pkg::ST_UP_PALM) begin
                resp[0] = trist_pkg::EV_UP2;
                one_finger2();
            end
            if (both_up) begin
                both_up = 1'b0;
                resp[0] = trist_pkg::EV_UP1;
                resp[8] = trist_pkg::EV_UP2;
                both_fingers();
            end
            if (first_up) begin
                first_up = 1'b0;
                resp[0] = trist_pkg::EV_UP1;
                resp[8] = trist_pkg::EV_DOWN2;
                both_fingers();
            end
            if (second_up) begin
                second_up = 1'b0;
                resp[0] = trist_pkg::EV_DOWN1;
                resp[8] = trist_pkg::EV_UP2;
                both_fingers();
            end
        end
        if (g == 8'h05) resp[7] = 8'h07;
        if (g == 8'h01) resp[7] = 8'h03;
        if (g == 8'h03) resp[7] = 8'h05;
        if (g == 8'h07) resp[7] = 8'h01;
        if (g[2:0] != 3'd0) resp[6] = 8'h01;
        if (pout) begin
            resp[6] = 8'h03;
            resp[14] = 8'h03;
        end
        if (pin) begin
            resp[6] = 8'h04;
            resp[14] = 8'h04;
        end
    endfunction

    function automatic void decode_cmd();
        logic [7:0] b9, b15;
        b9 = rpt[9];
        b15 = rpt[15];
        case (cmdb[0])
            trist_pkg::CMD_STATUS: begin
                resp[0] = trist_pkg::ST_IDLE;
                if (b9[2] && b15[2]) resp[0] = trist_pkg::ST_EVENT;
                if (two_dn && !b9[0] && !b15[0]) begin
                    resp[0] = trist_pkg::ST_EVENT;
                    both_up = 1'b1;
                end
                if (two_dn && b9[2] && !b15[0]) begin
                    resp[0] = trist_pkg::ST_EVENT;
                    second_up = 1'b1;
                end
                if (two_dn && !b9[0] && b15[2]) begin
                    resp[0] = trist_pkg::ST_EVENT;
                    first_up = 1'b1;
                end
            end
            trist_pkg::CMD_AE: resp[0] = 8'h26;
            trist_pkg::CMD_E1: {resp[0], resp[1], resp[2], resp[3]} = 32'h0482_0700;
            trist_pkg::CMD_F6: begin
                {resp[0], resp[1], resp[2]} = 24'h555632;
                for (int i = 3; i < 8; i++) resp[i] = 8'h00;
                resp[8] = 8'h11;
                resp[9] = 8'h08;
            end
            trist_pkg::CMD_02: {resp[0], resp[1], resp[2], resp[3]} = 32'h5400_0000;
            trist_pkg::CMD_0B: {resp[0], resp[1], resp[2]} = 24'h130C00;
            trist_pkg::CMD_E2: resp[0] = 8'h82;
            trist_pkg::CMD_E3, trist_pkg::CMD_F3, trist_pkg::CMD_F4,
            trist_pkg::CMD_F5: resp[0] = 8'h07;
            trist_pkg::CMD_F0: resp[0] = 8'h04;
            trist_pkg::CMD_F1, trist_pkg::CMD_F2: resp[0] = 8'h45;
            trist_pkg::CMD_POINT: build_points();
            default: ;
        endcase
    endfunction

    function automatic t_reply slave_step(logic [2:0] op, logic [63:0] lo, logic [63:0] hi,
                                          logic [7:0] rx);
        t_reply r;
        r = '0;
        case (op)
            trist_pkg::OP_REPORT: store_report(lo, hi);
            trist_pkg::OP_ADDR: begin
                rx_idx = 0;
                tx_idx = 0;
            end
            trist_pkg::OP_RX: begin
                if (rx_idx < NBUF) begin
                    cmdb[rx_idx] = rx;
                    rx_idx++;
                end
                decode_cmd();
            end
            trist_pkg::OP_TX: begin
                r.tx_valid = 1'b1;
                n_tx++;
                if (tx_idx < NBUF) begin
                    r.tx_byte = resp[tx_idx];
                    tx_idx++;
                end
            end
            trist_pkg::OP_STOP: if (cmdb[0] == trist_pkg::CMD_POINT) hint = 1'b1;
            default: ;
        endcase
        r.int_level = hint;
        return r;
    endfunction

    task automatic send_word(logic [2:0] op, logic [63:0] lo, logic [63:0] hi, logic [7:0] rx,
                             logic has_exp, t_reply exp);
        t_reply p;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_report_low <= lo;
        i_report_high <= hi;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        p = slave_step(op, lo, hi, rx);
        if (has_exp && p != exp) begin
            $display("%0t table row disagrees: table %h model %h", $time, exp, p);
            errors++;
        end
        reply_q.push_back(p);
    endtask

    always @(posedge i_clk) begin
        t_reply got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_tx_byte, o_tx_valid, o_int_level};
            if (reply_q.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, got);
                errors++;
            end else begin
                want = reply_q.pop_front();
                n_checked++;
                if (got.tx_byte !== want.tx_byte || got.tx_valid !== want.tx_valid ||
                    got.int_level !== want.int_level) begin
                    $display("%0t mismatch: expected %h/%b/%b actual %h/%b/%b", $time,
                             want.tx_byte, want.tx_valid, want.int_level,
                             got.tx_byte, got.tx_valid, got.int_level);
                    errors++;
                end
            end
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic logic [7:0] status_byte();
        logic [7:0] s;
        s = 8'($urandom);
        if ($urandom_range(0, 2) == 0)
            s = $urandom_range(0, 1) ? trist_pkg::ST_UP : trist_pkg::ST_UP_PALM;
        return s;
    endfunction

    function automatic logic [63:0] rand_lo();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 1)) v[7:0] = {v[7:4], 1'b1, v[2:1], 1'b1};
        if ($urandom_range(0, 1)) v[23:16] = 8'($urandom_range(0, 7));
        return v;
    endfunction

    function automatic logic [63:0] rand_hi();
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[15:8] = status_byte();
        v[63:56] = status_byte();
        if ($urandom_range(0, 1)) v[47:40] = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) v[31:24] = v[47:40];
        return v;
    endfunction

    function automatic logic [7:0] rand_cmd();
        logic [7:0] c [16] = '{trist_pkg::CMD_STATUS, trist_pkg::CMD_POINT, trist_pkg::CMD_AE,
                               trist_pkg::CMD_E1, trist_pkg::CMD_F6, trist_pkg::CMD_02,
                               trist_pkg::CMD_0B, trist_pkg::CMD_E2, trist_pkg::CMD_E3,
                               trist_pkg::CMD_F3, trist_pkg::CMD_F4, trist_pkg::CMD_F5,
                               trist_pkg::CMD_F0, trist_pkg::CMD_F1, trist_pkg::CMD_F2,
                               trist_pkg::CMD_POINT};
        if ($urandom_range(0, 7) == 0) return 8'($urandom);
        return c[$urandom_range(0, 15)];
    endfunction

    task automatic host_transaction();
        int nrd;
        t_reply z;
        z = '0;
        if ($urandom_range(0, 2) != 0)
            send_word(trist_pkg::OP_REPORT, rand_lo(), rand_hi(), 8'($urandom), 1'b0, z);
        send_word(trist_pkg::OP_ADDR, {$urandom, $urandom}, {$urandom, $urandom},
                  8'($urandom), 1'b0, z);
        send_word(trist_pkg::OP_RX, 64'($urandom), 64'($urandom), rand_cmd(), 1'b0, z);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 18))
                send_word(trist_pkg::OP_RX, '0, '0, 8'($urandom), 1'b0, z);
        send_word(trist_pkg::OP_ADDR, '0, '0, '0, 1'b0, z);
        nrd = $urandom_range(0, 5) == 0 ? $urandom_range(14, 19) : $urandom_range(1, 4);
        repeat (nrd) send_word(trist_pkg::OP_TX, '0, '0, 8'($urandom), 1'b0, z);
        send_word(trist_pkg::OP_STOP, '0, '0, '0, 1'b0, z);
    endtask

    t_row rows [$];
    int   sent;

    initial begin
        t_row w;
        t_reply z;
        z = '0;
        for (int i = 0; i < 16; i++) begin
            rpt[i] = '0;
            resp[i] = '0;
            cmdb[i] = '0;
        end
        rx_idx = 0;
        tx_idx = 0;
        last_dist = '0;
        {pin, pout, two_dn, both_up, first_up, second_up} = '0;
        hint = 1'b1;
        // after reset: read gives zero, line idle
        rows.push_back('{trist_pkg::OP_TX, 0, 0, 0, 1, '{8'h00, 1'b1, 1'b1}});
        rows.push_back('{trist_pkg::OP_STOP, 0, 0, 0, 1, '{8'h00, 1'b0, 1'b1}});
        rows.push_back('{OP_NONE, '1, '1, '1, 1, '{8'h00, 1'b0, 1'b1}});
        rows.push_back('{OP_LAST, 0, 0, 0, 1, '{8'h00, 1'b0, 1'b1}});
        rows.push_back('{trist_pkg::OP_ADDR, 0, 0, 0, 1, '{8'h00, 1'b0, 1'b1}});
        rows.push_back('{trist_pkg::OP_RX, 0, 0, trist_pkg::CMD_E2, 1, '{8'h00, 1'b0, 1'b1}});
        rows.push_back('{trist_pkg::OP_ADDR, 0, 0, 0, 1, '{8'h00, 1'b0, 1'b1}});
        rows.push_back('{trist_pkg::OP_TX, 0, 0, 0, 1, '{8'h82, 1'b1, 1'b1}});
        // extreme coordinates, both fingers down and moving
        rows.push_back('{trist_pkg::OP_REPORT, 64'h0000_0000_0000_0009,
                         64'h0500_0000_FFFF_0500, 0, 1, '{8'h00, 1'b0, 1'b0}});
        rows.push_back('{trist_pkg::OP_REPORT, '1, '1, 0, 0, z});
        rows.push_back('{trist_pkg::OP_REPORT, 64'h0000_0000_0000_0009,
                         64'h0500_0000_FFFF_0500, 0, 0, z});
        rows.push_back('{trist_pkg::OP_ADDR, 0, 0, 0, 0, z});
        rows.push_back('{trist_pkg::OP_RX, 0, 0, trist_pkg::CMD_POINT, 0, z});
        rows.push_back('{trist_pkg::OP_ADDR, 0, 0, 0, 0, z});
        for (int i = 0; i < 17; i++) rows.push_back('{trist_pkg::OP_TX, 0, 0, 0, 0, z});
        rows.push_back('{trist_pkg::OP_STOP, 0, 0, 0, 1, '{8'h00, 1'b0, 1'b1}});
        // fill past the end of the command buffer
        rows.push_back('{trist_pkg::OP_ADDR, 0, 0, 0, 0, z});
        for (int i = 0; i < 18; i++) rows.push_back('{trist_pkg::OP_RX, 0, 0, 8'hFF, 0, z});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) begin
            w = rows[k];
            send_word(w.op, w.lo, w.hi, w.rx, w.has_exp, w.exp);
        end
        sent = rows.size();
        while (sent < 950) begin
            if ($urandom_range(0, 9) == 0)
                send_word(3'($urandom), rand_lo(), rand_hi(), 8'($urandom), 1'b0, z);
            else
                host_transaction();
            sent = n_checked + reply_q.size();
            if (sent > 800) quiet = 1'b1;
        end
        i_valid <= 1'b0;
        all_sent = 1'b1;
    end

    initial begin
        wait (all_sent);
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("Checked %0d words, %0d reads, %0d point record builds.",
                 n_checked, n_tx, n_point);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
